// ===== hdl/pdlc_pkg.sv =====
// Package for the combination lock controller: item types, codes and constants.
// Used by pdlc_core, pdlc_out_fifo and password_door_lock_controller.
`default_nettype none

package pdlc_pkg;

  localparam int CODE_LENGTH_DEF = 5;
  localparam int OUT_DEPTH       = 4;

  localparam logic [7:0] OPEN_BYTE        = 8'd45;
  localparam logic [7:0] CHANGE_BYTE      = 8'd43;
  localparam logic [7:0] MOTOR_TICKS_RST  = 8'd15;
  localparam logic [2:0] MAX_ATTEMPTS_RST = 3'd3;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [1:0] REG_MOTOR_TICKS  = 2'd0;
  localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic reply_valid;
    logic reply_value;
    logic motor_forward;
    logic motor_reverse;
    logic alarm_on;
    logic last;
  } out_item_t;

  // One accepted item leaves one result, or a pair when pair is set.
  typedef struct packed {
    logic      push;
    logic      pair;
    out_item_t first;
    out_item_t second;
  } result_push_t;

endpackage

`default_nettype wire

// ===== hdl/password_door_lock_controller.sv =====
// Combination lock controller, top level. Each accepted item's results are written into
// the result buffer and offered on the output in order, a pair's first item ahead of its second.
// Throughput: one item per cycle while the result buffer has room for a pair (in_ready);
// a correct code change leaves a pair of results on the output.
// Reset (synchronous): waits for start, no code present, alarm off, motor_ticks 15,
// max_attempts 3, result buffer empty; code stores hold no defined value.
`default_nettype none

module password_door_lock_controller #(
  parameter int CODE_LENGTH = pdlc_pkg::CODE_LENGTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire pdlc_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pdlc_pkg::out_item_t     out_data,
  input  wire logic               cfg_wr_en,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [7:0]         cfg_data
);
  import pdlc_pkg::*;

  result_push_t results;
  logic         fire;

  assign fire = in_valid && in_ready;

  pdlc_core #(
    .CODE_LENGTH(CODE_LENGTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (in_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .results  (results)
  );

  pdlc_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .results  (results),
    .space    (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("accepted item left no result");

  a_pair_head: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> out_data.reply_valid && out_data.reply_value)
    else $error("non-final result is not an accept reply");

  a_motor_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.motor_forward && out_data.motor_reverse))
    else $error("motor driven both ways");

  a_reply_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.reply_value |-> out_data.reply_valid)
    else $error("reply value without reply");

endmodule

`default_nettype wire

// ===== hdl/pdlc_core.sv =====
// Lock state machine, code stores and configuration registers.
// Depends on pdlc_pkg; produces the results of each accepted item in the same cycle.
`default_nettype none

module pdlc_core #(
  parameter int CODE_LENGTH = pdlc_pkg::CODE_LENGTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   fire,
  input  wire pdlc_pkg::in_item_t     item,
  input  wire logic                   cfg_wr_en,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [7:0]             cfg_data,
  output pdlc_pkg::result_push_t      results
);
  import pdlc_pkg::*;

  localparam int POS_W = $clog2(CODE_LENGTH + 1);
  localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(CODE_LENGTH);

  typedef enum logic [6:0] {
    PH_WAIT_START    = 7'b0000001,
    PH_SETUP_FIRST   = 7'b0000010,
    PH_SETUP_CONFIRM = 7'b0000100,
    PH_IDLE          = 7'b0001000,
    PH_ATTEMPT       = 7'b0010000,
    PH_MOTOR_FWD     = 7'b0100000,
    PH_MOTOR_REV     = 7'b1000000
  } phase_t;

  logic [7:0]       motor_ticks;
  logic [2:0]       max_attempts;
  logic [7:0]       stored_code [CODE_LENGTH];
  logic [7:0]       first_entry [CODE_LENGTH];

  phase_t           phase, phase_next;
  logic             code_present, code_present_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             mismatch_seen, mismatch_seen_next;
  logic [2:0]       tries_used, tries_used_next;
  logic             request_is_change, request_is_change_next;
  logic [7:0]       tick_count, tick_count_next;
  logic             alarm_latch, alarm_latch_next;

  logic             first_we;
  logic             store_en;
  logic [1:0]       reply_cnt;
  logic             reply_val;

  logic [IDX_W-1:0] idx;
  logic [POS_W-1:0] pos_inc;
  logic             pos_ok;
  logic             pos_done;
  logic             miss_first;
  logic             miss_stored;
  logic [7:0]       tick_inc;
  logic [2:0]       tries_inc;

  assign idx         = byte_position[IDX_W-1:0];
  assign pos_inc     = byte_position + 1'b1;
  assign pos_ok      = byte_position < LAST_POS;
  assign pos_done    = pos_inc == LAST_POS;
  assign miss_first  = item.data_byte != first_entry[idx];
  assign miss_stored = item.data_byte != stored_code[idx];
  assign tick_inc    = tick_count + 8'd1;
  assign tries_inc   = tries_used + 3'd1;

  always_comb begin
    phase_next             = phase;
    code_present_next      = code_present;
    byte_position_next     = byte_position;
    mismatch_seen_next     = mismatch_seen;
    tries_used_next        = tries_used;
    request_is_change_next = request_is_change;
    tick_count_next        = tick_count;
    alarm_latch_next       = alarm_latch;
    first_we               = 1'b0;
    store_en               = 1'b0;
    reply_cnt              = 2'd0;
    reply_val              = 1'b0;

    case (item.kind)
      KIND_START: begin
        tick_count_next  = 8'd0;
        alarm_latch_next = 1'b0;
        reply_cnt        = 2'd1;
        if (code_present) begin
          phase_next = PH_IDLE;
          reply_val  = 1'b1;
        end else begin
          phase_next         = PH_SETUP_FIRST;
          byte_position_next = '0;
          mismatch_seen_next = 1'b0;
        end
      end
      KIND_BYTE: begin
        unique case (phase)
          PH_SETUP_FIRST: begin
            if (pos_ok) begin
              first_we           = 1'b1;
              byte_position_next = pos_inc;
              if (pos_done) begin
                phase_next         = PH_SETUP_CONFIRM;
                byte_position_next = '0;
                mismatch_seen_next = 1'b0;
              end
            end
          end
          PH_SETUP_CONFIRM: begin
            if (pos_ok) begin
              mismatch_seen_next = mismatch_seen | miss_first;
              byte_position_next = pos_inc;
              if (pos_done) begin
                reply_cnt          = 2'd1;
                byte_position_next = '0;
                mismatch_seen_next = 1'b0;
                if (!(mismatch_seen | miss_first)) begin
                  store_en          = 1'b1;
                  code_present_next = 1'b1;
                  phase_next        = PH_IDLE;
                  reply_val         = 1'b1;
                end else begin
                  phase_next = PH_SETUP_FIRST;
                end
              end
            end
          end
          PH_IDLE: begin
            if (item.data_byte == OPEN_BYTE || item.data_byte == CHANGE_BYTE) begin
              request_is_change_next = item.data_byte == CHANGE_BYTE;
              tries_used_next        = 3'd0;
              byte_position_next     = '0;
              mismatch_seen_next     = 1'b0;
              phase_next             = PH_ATTEMPT;
            end
          end
          PH_ATTEMPT: begin
            if (pos_ok) begin
              mismatch_seen_next = mismatch_seen | miss_stored;
              byte_position_next = pos_inc;
              if (pos_done) begin
                byte_position_next = '0;
                reply_cnt          = 2'd1;
                if (!(mismatch_seen | miss_stored)) begin
                  reply_val = 1'b1;
                  if (request_is_change) begin
                    // Drop the code and prompt for a new one right away.
                    code_present_next  = 1'b0;
                    alarm_latch_next   = 1'b0;
                    phase_next         = PH_SETUP_FIRST;
                    mismatch_seen_next = 1'b0;
                    reply_cnt          = 2'd2;
                  end else begin
                    phase_next      = PH_MOTOR_FWD;
                    tick_count_next = 8'd0;
                  end
                end else begin
                  tries_used_next    = tries_inc;
                  mismatch_seen_next = 1'b0;
                  if (tries_inc >= max_attempts || tries_inc == 3'd0) begin
                    alarm_latch_next = 1'b1;
                    phase_next       = PH_IDLE;
                  end
                end
              end
            end
          end
          default: begin
          end
        endcase
      end
      KIND_TICK: begin
        if (phase == PH_MOTOR_FWD || phase == PH_MOTOR_REV) begin
          tick_count_next = tick_inc;
          if (tick_inc == motor_ticks) begin
            tick_count_next = 8'd0;
            phase_next      = (phase == PH_MOTOR_FWD) ? PH_MOTOR_REV : PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result items carry the motor and alarm state after this item.
  always_comb begin
    results.push                 = fire;
    results.pair                 = reply_cnt == 2'd2;
    results.first.reply_valid    = reply_cnt != 2'd0;
    results.first.reply_value    = reply_val;
    results.first.motor_forward  = phase_next == PH_MOTOR_FWD;
    results.first.motor_reverse  = phase_next == PH_MOTOR_REV;
    results.first.alarm_on       = alarm_latch_next;
    results.first.last           = reply_cnt != 2'd2;
    results.second               = results.first;
    results.second.reply_value   = 1'b0;
    results.second.last          = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motor_ticks       <= MOTOR_TICKS_RST;
      max_attempts      <= MAX_ATTEMPTS_RST;
      phase             <= PH_WAIT_START;
      code_present      <= 1'b0;
      byte_position     <= '0;
      mismatch_seen     <= 1'b0;
      tries_used        <= 3'd0;
      request_is_change <= 1'b0;
      tick_count        <= 8'd0;
      alarm_latch       <= 1'b0;
    end else begin
      if (cfg_wr_en && cfg_index == REG_MOTOR_TICKS) begin
        motor_ticks <= cfg_data;
      end
      if (cfg_wr_en && cfg_index == REG_MAX_ATTEMPTS) begin
        max_attempts <= cfg_data[2:0];
      end
      if (fire) begin
        phase             <= phase_next;
        code_present      <= code_present_next;
        byte_position     <= byte_position_next;
        mismatch_seen     <= mismatch_seen_next;
        tries_used        <= tries_used_next;
        request_is_change <= request_is_change_next;
        tick_count        <= tick_count_next;
        alarm_latch       <= alarm_latch_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && first_we) begin
      first_entry[idx] <= item.data_byte;
    end
    if (fire && store_en) begin
      for (int i = 0; i < CODE_LENGTH; i++) begin
        stored_code[i] <= first_entry[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pdlc_out_fifo.sv =====
// Result buffer: takes one or two result items per cycle, hands out one while out_ready is high.
// Depends on pdlc_pkg for the item and push types.
`default_nettype none

module pdlc_out_fifo (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire pdlc_pkg::result_push_t results,
  output logic                        space,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output pdlc_pkg::out_item_t         out_data
);
  import pdlc_pkg::*;

  localparam int PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  out_item_t        entries [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;
  logic [CNT_W-1:0] push_cnt;

  assign out_valid = count != '0;
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  // Keep room for a pair whatever the output side does.
  assign space     = count <= CNT_W'(OUT_DEPTH - 2);
  assign push_cnt  = !results.push ? CNT_W'(0) : (results.pair ? CNT_W'(2) : CNT_W'(1));
  assign wr_ptr_next = wr_ptr + 1'b1;
  assign count_next  = count + push_cnt - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt[PTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (results.push) begin
      entries[wr_ptr] <= results.first;
      if (results.pair) begin
        entries[wr_ptr_next] <= results.second;
      end
    end
  end

endmodule

`default_nettype wire
